// File: design/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define ASSERT_CLK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");

// property checked at every edge, reset included
`define ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("assertion failed");

`endif

// File: design/arfp_pkg.sv
// package of constants and types for the range frame parser
package arfp_pkg;

   // field widths
   localparam int BYTE_W      = 8;
   localparam int DIST_W      = 27;
   localparam int RSP_DATA_W  = 32;
   localparam int FRAME_LEN_W = 4;
   localparam int PROD_W      = DIST_W + 4;

   // frame limits
   localparam int MAX_FRAME_BYTES_DEFAULT = 11;
   localparam int MIN_VALID_BYTES         = 6;

   // character codes
   localparam logic [BYTE_W-1:0] BYTE_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] BYTE_DROP  = 8'hFF;
   localparam logic [BYTE_W-1:0] CHAR_R     = 8'h52;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

   // largest value the distance field holds
   localparam logic [PROD_W-1:0] VALUE_MAX = PROD_W'((64'd1 << DIST_W) - 64'd1);

   // frame status codes
   localparam logic STATUS_VALID   = 1'b0;
   localparam logic STATUS_INVALID = 1'b1;

   // result of one byte step
   typedef struct packed {
      logic              emit;
      logic [DIST_W-1:0] distance_mm;
      logic              frame_status;
   } arfp_result_type;

endpackage

// File: design/ascii_range_frame_parser.sv
// top level of the range frame parser
//
// The req channel carries one received serial byte per transfer. Bytes are
// assembled into text frames of the form 'R', digits, space, text, CR. The
// byte 0xFF is discarded without counting. A frame closes on CR or when it
// reaches MAX_FRAME_BYTES bytes; each closed frame gives one rsp transfer:
// tdata holds the range in millimetres, tuser is 0 for a valid reading and
// 1 for a discarded frame (range then 0).
// A byte that closes a frame passes from the input register through the
// tracker step into the result register, which drives rsp_tvalid; a
// receiver stall can hold it in the input register before that step.
// Throughput: one byte per cycle while the receiver does not stall, set by
// the single tracker step between the input register and the result register.
// Reset clears the frame state and the valid bits of both registers. When
// the receiver stalls, the pending result holds and the input register keeps
// one byte; req_tready drops once both are full.
module ascii_range_frame_parser
   import arfp_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,   // [7:0] rx_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [26:0] distance_mm, rest zero
   output logic [0:0]            rsp_tuser    // [0] frame_status
);

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;
   logic              out_valid_ff, out_valid_in;
   logic [DIST_W-1:0] out_dist_ff, out_dist_in;
   logic              out_status_ff, out_status_in;

   logic            advance, process, req_fire;
   arfp_result_type result;

   // handshake control
   always_comb begin
      advance    = !out_valid_ff || rsp_tready;
      process    = in_valid_ff && advance;
      req_tready = !in_valid_ff || advance;
      req_fire   = req_tvalid && req_tready;
   end

   arfp_tracker #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_tracker (
      .clock   (clock),
      .reset   (reset),
      .step_en (process),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   // next values of input and result registers
   always_comb begin
      in_valid_in   = req_fire ? 1'b1 : (process ? 1'b0 : in_valid_ff);
      in_byte_in    = req_fire ? req_tdata : in_byte_ff;
      out_dist_in   = out_dist_ff;
      out_status_in = out_status_ff;
      if (process && result.emit) begin
         out_valid_in  = 1'b1;
         out_dist_in   = result.distance_mm;
         out_status_in = result.frame_status;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_byte_ff    <= in_byte_in;
      out_dist_ff   <= out_dist_in;
      out_status_ff <= out_status_in;
   end

   // result port
   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = RSP_DATA_W'(out_dist_ff);
   assign rsp_tuser[0] = out_status_ff;

endmodule

// File: design/arfp_tracker.sv
// frame state tracker: inspects one byte and keeps the running frame state
module arfp_tracker
   import arfp_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic [BYTE_W-1:0] rx_byte,
   output arfp_result_type   result
);

   localparam int LEN_W = FRAME_LEN_W + 1;

   logic [FRAME_LEN_W-1:0] frame_length_ff, frame_length_in;
   logic                   first_is_r_ff, first_is_r_in;
   logic                   space_seen_ff, space_seen_in;
   logic                   number_bad_ff, number_bad_in;
   logic                   has_digit_ff, has_digit_in;
   logic [DIST_W-1:0]      value_ff, value_in;

   logic              is_drop, is_cr, is_space, is_digit;
   logic [3:0]        digit;
   logic [PROD_W-1:0] product;
   logic              overflow;
   logic [LEN_W-1:0]  len;
   logic              frame_done, frame_valid;

   // byte classes and the next decimal value
   always_comb begin
      is_drop  = (rx_byte == BYTE_DROP);
      is_cr    = (rx_byte == BYTE_CR);
      is_space = (rx_byte == CHAR_SPACE);
      is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
      digit    = 4'(rx_byte - CHAR_ZERO);
      product  = PROD_W'({value_ff, 3'b000}) + PROD_W'({value_ff, 1'b0}) + PROD_W'(digit);
      overflow = (product > VALUE_MAX);
      len      = {1'b0, frame_length_ff} + LEN_W'(1);
      frame_done  = is_cr || (len >= LEN_W'(MAX_FRAME_BYTES));
      frame_valid = (len >= LEN_W'(MIN_VALID_BYTES)) && first_is_r_ff && is_cr;
   end

   // result of this byte
   always_comb begin
      result.emit         = !is_drop && frame_done;
      result.frame_status = frame_valid ? STATUS_VALID : STATUS_INVALID;
      if (frame_valid && space_seen_ff && has_digit_ff && !number_bad_ff) begin
         result.distance_mm = value_ff;
      end else begin
         result.distance_mm = '0;
      end
   end

   // next frame state
   always_comb begin
      frame_length_in = frame_length_ff;
      first_is_r_in   = first_is_r_ff;
      space_seen_in   = space_seen_ff;
      number_bad_in   = number_bad_ff;
      has_digit_in    = has_digit_ff;
      value_in        = value_ff;
      if (step_en && !is_drop) begin
         if (frame_done) begin
            frame_length_in = '0;
            first_is_r_in   = 1'b0;
            space_seen_in   = 1'b0;
            number_bad_in   = 1'b0;
            has_digit_in    = 1'b0;
            value_in        = '0;
         end else begin
            frame_length_in = len[FRAME_LEN_W-1:0];
            if (frame_length_ff == '0) begin
               first_is_r_in = (rx_byte == CHAR_R);
            end else if (!space_seen_ff) begin
               if (is_space) begin
                  space_seen_in = 1'b1;
               end else if (is_digit) begin
                  has_digit_in = 1'b1;
                  if (!number_bad_ff) begin
                     if (overflow) begin
                        number_bad_in = 1'b1;
                     end else begin
                        value_in = product[DIST_W-1:0];
                     end
                  end
               end else begin
                  number_bad_in = 1'b1;
               end
            end
         end
      end
   end

   // frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff <= '0;
         first_is_r_ff   <= 1'b0;
         space_seen_ff   <= 1'b0;
         number_bad_ff   <= 1'b0;
         has_digit_ff    <= 1'b0;
         value_ff        <= '0;
      end else begin
         frame_length_ff <= frame_length_in;
         first_is_r_ff   <= first_is_r_in;
         space_seen_ff   <= space_seen_in;
         number_bad_ff   <= number_bad_in;
         has_digit_ff    <= has_digit_in;
         value_ff        <= value_in;
      end
   end

endmodule

// File: design/arfp_checker.sv
// port-level checker for the range frame parser, with its bind
`include "assert_macros.svh"

module arfp_checker
   import arfp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [BYTE_W-1:0]     req_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [0:0]            rsp_tuser
);

   logic req_fire, rsp_stall, drop_fire;

   // handshake terms
   assign req_fire  = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign drop_fire = req_fire && (req_tdata == BYTE_DROP);

   // nothing pending right after reset
   `ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid)

   // a stalled result holds
   `ASSERT_CLK(a_rsp_hold, rsp_stall |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // a discarded frame carries no range
   `ASSERT_CLK(a_invalid_zero, rsp_tvalid && (rsp_tuser[0] == STATUS_INVALID) |-> rsp_tdata == '0)

   // a dropped byte on an empty block raises no result
   `ASSERT_CLK(a_drop_silent, drop_fire && !rsp_tvalid && !$past(req_fire) |=> ##1 !rsp_tvalid)

   // padding bits above the range stay zero
   `ASSERT_CLK(a_pad_zero, rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:DIST_W] == '0)

endmodule

bind ascii_range_frame_parser arfp_checker u_arfp_checker (.*);

// File: verif/testbench.sv
// self-checking testbench for the range frame parser, with its own frame predictor
module testbench
   import arfp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_LIMIT    = MAX_FRAME_BYTES_DEFAULT;
   localparam int RANDOM_BYTES   = 900;
   localparam int DRAIN_EVERY    = 150;
   localparam int HOLD_AFTER     = 300;
   localparam int LONG_HOLD      = 150;
   localparam int WATCHDOG_LIMIT = 2000;

   // one received byte waiting to be sent, optionally after all results are back
   typedef struct {
      logic [BYTE_W-1:0] rx_byte;
      bit                drain_first;
   } rx_item_type;

   // one expected frame outcome
   typedef struct {
      logic [DIST_W-1:0] distance_mm;
      logic              frame_status;
   } range_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]            rsp_tuser;

   rx_item_type      pending_rx[$];
   range_result_type range_expect_q[$];
   range_result_type oldest_frame;

   // predictor copy of the frame tracker
   logic [FRAME_LEN_W-1:0] frame_len   = '0;
   logic                   lead_is_r   = 1'b0;
   logic                   space_found = 1'b0;
   logic                   digits_bad  = 1'b0;
   logic                   digit_found = 1'b0;
   logic [DIST_W-1:0]      digit_value = '0;

   int tx_gap, calm_tx, rx_stall, calm_rx, hold_left, quiet_cycles;
   int bytes_accepted, frames_checked, valid_frames, mismatches, stim_bytes;
   bit long_hold_done;

   ascii_range_frame_parser #(
      .MAX_FRAME_BYTES(FRAME_LIMIT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // clock generation
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // idle length: mostly none, some short, a few long
   function automatic int idle_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // advance the frame tracker by one accepted byte, queue the outcome on frame close
   task automatic track_byte(input logic [BYTE_W-1:0] rx);
      int unsigned       count_now;
      logic [PROD_W-1:0] next_value;
      range_result_type  outcome;
      if (rx == BYTE_DROP) return;
      if (frame_len == 0) begin
         lead_is_r = (rx == CHAR_R);
      end else if (!space_found) begin
         if (rx == CHAR_SPACE) begin
            space_found = 1'b1;
         end else if (rx >= CHAR_ZERO && rx <= CHAR_NINE) begin
            if (!digits_bad) begin
               next_value = PROD_W'(digit_value) * PROD_W'(10) + PROD_W'(rx - CHAR_ZERO);
               if (next_value > VALUE_MAX) digits_bad = 1'b1;
               else digit_value = next_value[DIST_W-1:0];
            end
            digit_found = 1'b1;
         end else begin
            digits_bad = 1'b1;
         end
      end
      count_now = frame_len + 1;
      frame_len = count_now[FRAME_LEN_W-1:0];
      if (rx != BYTE_CR && count_now < FRAME_LIMIT) return;
      // frame closed: valid reading or discarded frame
      if (count_now >= MIN_VALID_BYTES && lead_is_r && rx == BYTE_CR) begin
         outcome.frame_status = STATUS_VALID;
         outcome.distance_mm  = (space_found && digit_found && !digits_bad) ? digit_value : '0;
      end else begin
         outcome.frame_status = STATUS_INVALID;
         outcome.distance_mm  = '0;
      end
      range_expect_q.push_back(outcome);
      frame_len   = '0;
      lead_is_r   = 1'b0;
      space_found = 1'b0;
      digits_bad  = 1'b0;
      digit_found = 1'b0;
      digit_value = '0;
   endtask

   task automatic queue_byte(input logic [BYTE_W-1:0] b, input bit drain);
      rx_item_type item;
      item.rx_byte     = b;
      item.drain_first = drain;
      pending_rx.push_back(item);
      if (b != BYTE_DROP) stim_bytes++;
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) queue_byte(s[i], 1'b0);
   endtask

   // random byte that neither closes a frame nor gets dropped
   function automatic logic [BYTE_W-1:0] plain_byte();
      logic [BYTE_W-1:0] b;
      do b = 8'($urandom_range(0, 254)); while (b == BYTE_CR);
      return b;
   endfunction

   // driver: req transfers from the pending queue, with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         tx_gap     <= 0;
         calm_tx    <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            track_byte(req_tdata);
            bytes_accepted <= bytes_accepted + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (tx_gap > 0) begin
               tx_gap     <= tx_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_rx.size() > 0 &&
                         !(pending_rx[0].drain_first && range_expect_q.size() > 0)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_rx[0].rx_byte;
               void'(pending_rx.pop_front());
               // occasional stretch with no gaps at all
               if (calm_tx > 0) begin
                  calm_tx <= calm_tx - 1;
                  tx_gap  <= 0;
               end else begin
                  tx_gap <= idle_len();
                  if ($urandom_range(0, 19) == 0) calm_tx <= $urandom_range(30, 80);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each rsp transfer against the oldest expected frame
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_stall   <= 0;
         calm_rx    <= 0;
         hold_left  <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            frames_checked <= frames_checked + 1;
            if (range_expect_q.size() == 0) begin
               $error("result with no frame pending: distance_mm %0d frame_status %0d",
                      rsp_tdata[DIST_W-1:0], rsp_tuser[0]);
               mismatches++;
            end else begin
               oldest_frame = range_expect_q.pop_front();
               if (oldest_frame.frame_status == STATUS_VALID) valid_frames <= valid_frames + 1;
               if (rsp_tdata[DIST_W-1:0] !== oldest_frame.distance_mm) begin
                  $error("distance_mm mismatch: expected %0d, actual %0d",
                         oldest_frame.distance_mm, rsp_tdata[DIST_W-1:0]);
                  mismatches++;
               end
               if (rsp_tuser[0] !== oldest_frame.frame_status) begin
                  $error("frame_status mismatch: expected %0d, actual %0d",
                         oldest_frame.frame_status, rsp_tuser[0]);
                  mismatches++;
               end
            end
         end
         // ready pattern: one long hold-off, otherwise random stalls
         if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (!long_hold_done && bytes_accepted >= HOLD_AFTER) begin
            long_hold_done <= 1'b1;
            hold_left      <= LONG_HOLD;
            rsp_tready     <= 1'b0;
         end else if (rx_stall > 0) begin
            rx_stall   <= rx_stall - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (calm_rx > 0) begin
               calm_rx <= calm_rx - 1;
            end else begin
               rx_stall <= idle_len();
               if ($urandom_range(0, 19) == 0) calm_rx <= $urandom_range(30, 80);
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // stimulus and end of run
   initial begin
      int  kind, digits, tail, spoil_at, next_drain;
      bit  drain;
      logic [BYTE_W-1:0] b;

      // largest eight-digit value at full length, closed by cr on the last byte
      queue_text("R99999999 ");
      queue_byte(BYTE_CR, 1'b0);
      // dropped byte inside a minimum-length frame
      queue_text("R0");
      queue_byte(BYTE_DROP, 1'b0);
      queue_text("1 x");
      queue_byte(BYTE_CR, 1'b0);
      // space in first position
      queue_text(" R12 ");
      queue_byte(BYTE_CR, 1'b0);

      // random frames, mostly well formed
      next_drain = DRAIN_EVERY;
      while (stim_bytes < RANDOM_BYTES) begin
         drain = (stim_bytes >= next_drain);
         if (drain) next_drain += DRAIN_EVERY;
         kind = $urandom_range(0, 99);
         if (kind < 65) begin
            // reading frame, sometimes with a spoilt number
            digits   = $urandom_range(0, 1) ? 8 : $urandom_range(1, 8);
            tail     = $urandom_range(0, 8 - digits);
            if (digits + tail < 3) tail = 3 - digits;
            spoil_at = (kind >= 55) ? $urandom_range(0, digits - 1) : -1;
            queue_byte(CHAR_R, drain);
            for (int i = 0; i < digits; i++) begin
               if (i == spoil_at) begin
                  case ($urandom_range(0, 3))
                     0: b = "+";
                     1: b = "-";
                     2: b = 8'h09;
                     default: b = 8'($urandom_range(8'h3A, 8'h7E));
                  endcase
               end else begin
                  b = CHAR_ZERO + 8'($urandom_range(0, 9));
               end
               queue_byte(b, 1'b0);
               if ($urandom_range(0, 19) == 0) queue_byte(BYTE_DROP, 1'b0);
            end
            queue_byte(CHAR_SPACE, 1'b0);
            for (int i = 0; i < tail; i++) queue_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
            queue_byte(BYTE_CR, 1'b0);
         end else if (kind < 72) begin
            // digits with no space, short ones included
            queue_byte(CHAR_R, drain);
            digits = $urandom_range(1, FRAME_LIMIT - 2);
            for (int i = 0; i < digits; i++) queue_byte(CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
            queue_byte(BYTE_CR, 1'b0);
         end else if (kind < 78) begin
            // space straight after the lead, no digit
            queue_byte(CHAR_R, drain);
            queue_byte(CHAR_SPACE, 1'b0);
            tail = $urandom_range(0, FRAME_LIMIT - 3);
            for (int i = 0; i < tail; i++) queue_byte(plain_byte(), 1'b0);
            queue_byte(BYTE_CR, 1'b0);
         end else if (kind < 86) begin
            // frame cut at the length limit, no cr
            queue_byte($urandom_range(0, 1) ? CHAR_R : plain_byte(), drain);
            for (int i = 1; i < FRAME_LIMIT; i++) begin
               queue_byte(plain_byte(), 1'b0);
               if ($urandom_range(0, 19) == 0) queue_byte(BYTE_DROP, 1'b0);
            end
         end else begin
            // noise of any value, then cr to realign
            tail = $urandom_range(0, 12);
            queue_byte(8'($urandom_range(0, 255)), drain);
            for (int i = 0; i < tail; i++) queue_byte(8'($urandom_range(0, 255)), 1'b0);
            queue_byte(BYTE_CR, 1'b0);
         end
      end

      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_rx.size() > 0 || req_tvalid || range_expect_q.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);

      $display("run covered %0d bytes in, %0d frames out (%0d valid readings)",
               bytes_accepted, frames_checked, valid_frames);
      $display("with random gaps on both sides, one long receiver hold-off and drain pauses");
      if (mismatches == 0 && range_expect_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
